/* design/ihb_pkg.sv */
// ihb_pkg: shared types, constants and header helpers for the ipv4 header builder
// no dependencies; imported by the front end, queue, serialiser and top level

package ihb_pkg;

  localparam int HDR_BYTES  = 20;
  localparam int HDR_WORDS  = 10;
  localparam int BYTE_IDX_W = 5;
  localparam int WORD_IDX_W = 4;

  localparam logic [WORD_IDX_W-1:0] CSUM_WORD = 4'd5;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = 4'd9;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 5'd19;

  // one header request
  typedef struct packed {
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] datagram_length;
    logic [15:0] ident;
    logic [2:0]  frag_flags;
    logic [12:0] frag_offset;
    logic [7:0]  hop_limit;
    logic [7:0]  proto_number;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } in_t;

  // one serialised header byte
  typedef struct packed {
    logic [7:0]            header_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic                  final_byte;
    logic [15:0]           computed_checksum;
  } out_t;

  // header with its finished checksum, held in the queue
  typedef struct packed {
    in_t         hdr;
    logic [15:0] csum;
  } rec_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_SUM,
    FE_HOLD
  } fe_state_t;

  // big-endian 16-bit header word, checksum field read as zero
  function automatic logic [15:0] hdr_word(input in_t h, input logic [WORD_IDX_W-1:0] idx);
    logic [15:0] w;
    begin
      unique case (idx)
        4'd0:    w = {h.ip_version, h.header_words, h.service_type};
        4'd1:    w = h.datagram_length;
        4'd2:    w = h.ident;
        4'd3:    w = {h.frag_flags, h.frag_offset};
        4'd4:    w = {h.hop_limit, h.proto_number};
        4'd6:    w = h.src_addr[31:16];
        4'd7:    w = h.src_addr[15:0];
        4'd8:    w = h.dst_addr[31:16];
        4'd9:    w = h.dst_addr[15:0];
        default: w = 16'h0000;
      endcase
      return w;
    end
  endfunction

  // header byte at a position, checksum inserted
  function automatic logic [7:0] hdr_byte(input rec_t r, input logic [BYTE_IDX_W-1:0] idx);
    logic [15:0] w;
    begin
      if (idx[BYTE_IDX_W-1:1] == CSUM_WORD) begin
        w = r.csum;
      end else begin
        w = hdr_word(r.hdr, idx[BYTE_IDX_W-1:1]);
      end
      return idx[0] ? w[7:0] : w[15:8];
    end
  endfunction

endpackage

/* design/ipv4_header_builder.sv */
// ipv4_header_builder: top level, ipv4 header serialiser with checksum generation
// depends on ihb_pkg, ihb_front, ihb_queue and ihb_serialiser
//
//   channel   ports                  transaction taken when
//   --------  ---------------------  -------------------------------------
//   request   start, busy, in_hdr    rising edge with start high, busy low
//   result    out_strobe, out_res    every edge ending a cycle with strobe
//
// each request gives twenty result transactions, bytes 0 to 19 in network order
// the front end sums one header word per cycle, then hands off to the queue
// the byte serialiser sets the sustained rate, sending queued records back to back
// a request passes through summing, the queue and the serialiser's output register
// reset (rst_n low, synchronous) empties the queue and idles both halves
// the receiver cannot stall; busy rises only while summing or with the queue full

module ipv4_header_builder #(
  parameter int QUEUE_DEPTH = 2   // records buffered between summing and serialising
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ihb_pkg::in_t  in_hdr,
  output logic          out_strobe,
  output ihb_pkg::out_t out_res
);
  import ihb_pkg::*;

  // handoff between front end and queue
  logic q_push, q_full;
  rec_t q_push_data;

  // handoff between queue and serialiser
  logic q_pop, q_empty;
  rec_t q_pop_data;

  // front end: takes the request and works out the checksum
  ihb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_hdr (in_hdr),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // decouples the two halves so a new request can be summed while bytes go out
  ihb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // back end: one header byte per cycle, next record picked up on the last byte
  ihb_serialiser u_serialiser (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

/* design/ihb_front.sv */
// ihb_front: accepts header requests and sums the ten header words, one per cycle
// depends on ihb_pkg; feeds finished records into ihb_queue

module ihb_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  ihb_pkg::in_t in_hdr,
  input  logic         q_full,
  output logic         q_push,
  output ihb_pkg::rec_t q_data
);
  import ihb_pkg::*;

  fe_state_t             state_r, state_nxt;
  in_t                   hdr_r, hdr_nxt;
  logic [15:0]           sum_r, sum_nxt;
  logic [WORD_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                  accept;

  // ones-complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    end
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: begin
        if (start) state_nxt = FE_SUM;
      end
      FE_SUM: begin
        if (cnt_r == LAST_WORD) state_nxt = FE_HOLD;
      end
      FE_HOLD: begin
        if (!q_full) state_nxt = start ? FE_SUM : FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = 1'b0;
    q_push = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        busy = 1'b0;
      end
      FE_SUM: begin
        busy = 1'b1;
      end
      FE_HOLD: begin
        busy   = q_full;
        q_push = !q_full;
      end
      default: busy = 1'b1;
    endcase
  end

  assign accept      = start && !busy;
  assign q_data.hdr  = hdr_r;
  assign q_data.csum = ~sum_r;

  // datapath
  always_comb begin
    hdr_nxt = hdr_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      hdr_nxt = in_hdr;
      sum_nxt = 16'h0000;
      cnt_nxt = '0;
    end else if (state_r == FE_SUM) begin
      sum_nxt = fold_add(sum_r, hdr_word(hdr_r, cnt_r));
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    sum_r <= sum_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

/* design/ihb_queue.sv */
// ihb_queue: small first-in first-out queue of finished header records
// depends on ihb_pkg; sits between ihb_front and ihb_serialiser

module ihb_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ihb_pkg::rec_t push_data,
  output logic          full,
  input  logic          pop,
  output ihb_pkg::rec_t pop_data,
  output logic          empty
);
  import ihb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/ihb_serialiser.sv */
// ihb_serialiser: pops header records and emits them one byte per cycle
// depends on ihb_pkg; drains ihb_queue and drives the registered result port

module ihb_serialiser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  ihb_pkg::rec_t q_data,
  output logic          q_pop,
  output logic          out_strobe,
  output ihb_pkg::out_t out_res
);
  import ihb_pkg::*;

  rec_t                  cur_r, cur_nxt;
  logic                  active_r, active_nxt;
  logic [BYTE_IDX_W-1:0] idx_r, idx_nxt;
  logic                  strobe_r, strobe_nxt;
  out_t                  res_r, res_nxt;
  logic                  last;

  assign last  = active_r && (idx_r == LAST_BYTE);
  assign q_pop = (!active_r || last) && !q_empty;

  always_comb begin
    cur_nxt    = cur_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (q_pop) begin
      cur_nxt    = q_data;
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    strobe_nxt                = active_r;
    res_nxt.header_byte       = hdr_byte(cur_r, idx_r);
    res_nxt.byte_index        = idx_r;
    res_nxt.final_byte        = (idx_r == LAST_BYTE);
    res_nxt.computed_checksum = cur_r.csum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

/* tb/sv/ipv4_header_builder_tb.sv */
// ipv4_header_builder_tb: self-checking bench for the ipv4 header serialiser and checksum
// depends on ihb_pkg and ipv4_header_builder; predicts all twenty bytes of each request

module ipv4_header_builder_tb;
  import ihb_pkg::*;

  localparam int DIR_ROWS     = 14;
  localparam int RAND_ITEMS   = 310;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES  = 40;    // settle time after the last expected byte
  localparam int MAX_REPORTS  = 40;

  // one directed row: header fields, plus a checksum typed in where it is obvious
  typedef struct packed {
    in_t         hdr;
    logic        csum_given;
    logic [15:0] csum;
  } dir_row_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_hdr;
  logic  out_strobe;
  out_t  out_res;

  // travel alongside in_hdr so the accept side knows whether a checksum was typed in
  logic        row_csum_given;
  logic [15:0] row_csum;

  out_t hdr_bytes_due [$];
  int   mismatch_count;

  ipv4_header_builder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_hdr     (in_hdr),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // header byte at a position in network order, with the given checksum in bytes 10 and 11
  function automatic logic [7:0] wire_byte(input in_t h, input logic [15:0] csum,
                                           input int idx);
    logic [159:0] flat;
    flat = {h.ip_version, h.header_words, h.service_type, h.datagram_length, h.ident,
            h.frag_flags, h.frag_offset, h.hop_limit, h.proto_number, csum,
            h.src_addr, h.dst_addr};
    return flat[159 - 8*idx -: 8];
  endfunction

  // complement of the ones-complement sum of the ten words, checksum field at zero, end-around carry
  function automatic logic [15:0] predict_csum(input in_t h);
    logic [16:0] acc;
    logic [15:0] word;
    acc = '0;
    for (int w = 0; w < HDR_WORDS; w++) begin
      word = {wire_byte(h, 16'h0000, 2*w), wire_byte(h, 16'h0000, 2*w + 1)};
      acc  = {1'b0, acc[15:0]} + {1'b0, word};
      acc  = {1'b0, acc[15:0]} + {16'h0000, acc[16]};
    end
    return ~acc[15:0];
  endfunction

  // queue the twenty bytes one request should produce
  task automatic expect_header_bytes(input in_t h, input logic [15:0] csum);
    out_t b;
    for (int i = 0; i < HDR_BYTES; i++) begin
      b.header_byte       = wire_byte(h, csum, i);
      b.byte_index        = BYTE_IDX_W'(i);
      b.final_byte        = (i == HDR_BYTES - 1);
      b.computed_checksum = csum;
      hdr_bytes_due.push_back(b);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  // directed table: extremes, a textbook header, odd version and length nibbles,
  // several protocols, flag and offset extremes, and the carry fold case
  function automatic dir_row_t dir_row(input int n);
    dir_row_t r;
    case (n)
      // all-zero words: sum is zero, checksum all ones
      0:  r = {4'h0, 4'h0, 8'h00, 16'h0000, 16'h0000, 3'h0, 13'h0000, 8'h00, 8'h00,
               32'h00000000, 32'h00000000, 1'b1, 16'hffff};
      // every field at its maximum: sum folds to ffff, checksum zero
      1:  r = {4'hf, 4'hf, 8'hff, 16'hffff, 16'hffff, 3'h7, 13'h1fff, 8'hff, 8'hff,
               32'hffffffff, 32'hffffffff, 1'b1, 16'h0000};
      // the usual worked example of an ipv4 header carrying udp
      2:  r = {4'h4, 4'h5, 8'h00, 16'h0073, 16'h0000, 3'h2, 13'h0000, 8'h40, 8'h11,
               32'hc0a80001, 32'hc0a800c7, 1'b1, 16'hb861};
      // a single word of ffff
      3:  r = {4'h0, 4'h0, 8'h00, 16'hffff, 16'h0000, 3'h0, 13'h0000, 8'h00, 8'h00,
               32'h00000000, 32'h00000000, 1'b1, 16'h0000};
      // carry out of bit 15 folded back in
      4:  r = {4'h0, 4'h0, 8'h00, 16'hffff, 16'h0001, 3'h0, 13'h0000, 8'h00, 8'h00,
               32'h00000000, 32'h00000000, 1'b1, 16'hfffe};
      5:  r = {4'hf, 4'h0, 8'h12, 16'h0014, 16'h0001, 3'h0, 13'h0000, 8'h01, 8'h01,
               32'h0a000001, 32'h0a000002, 1'b0, 16'h0000};
      6:  r = {4'h0, 4'hf, 8'h34, 16'h003c, 16'h0002, 3'h0, 13'h0000, 8'h02, 8'h01,
               32'h0a000002, 32'h0a000001, 1'b0, 16'h0000};
      7:  r = {4'h4, 4'h5, 8'h10, 16'h0028, 16'hbeef, 3'h2, 13'h0000, 8'h40, 8'h06,
               32'hac100001, 32'hac1000fe, 1'b0, 16'h0000};
      8:  r = {4'h4, 4'h5, 8'h00, 16'h0200, 16'h1234, 3'h0, 13'h0000, 8'h80, 8'hff,
               32'h7f000001, 32'h7f000001, 1'b0, 16'h0000};
      9:  r = {4'h4, 4'h5, 8'h00, 16'h05dc, 16'h4321, 3'h7, 13'h0000, 8'h20, 8'h11,
               32'hc0000201, 32'hc6336402, 1'b0, 16'h0000};
      10: r = {4'h4, 4'h5, 8'h00, 16'h05dc, 16'h4321, 3'h0, 13'h1fff, 8'h20, 8'h11,
               32'hc0000201, 32'hc6336402, 1'b0, 16'h0000};
      11: r = {4'h4, 4'h6, 8'h00, 16'h0018, 16'h0000, 3'h1, 13'h0001, 8'h00, 8'h00,
               32'h80000000, 32'h00000001, 1'b0, 16'h0000};
      12: r = {4'h6, 4'h5, 8'h00, 16'hfffe, 16'h8000, 3'h4, 13'h1000, 8'hff, 8'h01,
               32'h01234567, 32'h89abcdef, 1'b0, 16'h0000};
      default: r = {4'h4, 4'h5, 8'hff, 16'h5a5a, 16'ha5a5, 3'h5, 13'h0aaa, 8'h01, 8'h02,
                    32'hfedcba98, 32'h76543210, 1'b0, 16'h0000};
    endcase
    return r;
  endfunction

  // mostly random, sometimes pinned to zero or to all ones
  function automatic logic [31:0] field_value(input int unsigned width);
    logic [31:0] mask;
    int unsigned pick;
    mask = (width >= 32) ? 32'hffffffff : ((32'h1 << width) - 1);
    pick = $urandom_range(9);
    if (pick == 0) return 32'h0;
    if (pick == 1) return mask;
    return $urandom & mask;
  endfunction

  function automatic in_t random_header();
    in_t h;
    h.ip_version      = 4'(field_value(4));
    h.header_words    = 4'(field_value(4));
    h.service_type    = 8'(field_value(8));
    h.datagram_length = 16'(field_value(16));
    h.ident           = 16'(field_value(16));
    h.frag_flags      = 3'(field_value(3));
    h.frag_offset     = 13'(field_value(13));
    h.hop_limit       = 8'(field_value(8));
    h.proto_number    = 8'(field_value(8));
    h.src_addr        = field_value(32);
    h.dst_addr        = field_value(32);
    // most requests look like real headers
    if ($urandom_range(99) < 75) begin
      h.ip_version   = 4'h4;
      h.header_words = 4'h5;
      case ($urandom_range(2))
        0:       h.proto_number = 8'd1;
        1:       h.proto_number = 8'd6;
        default: h.proto_number = 8'd17;
      endcase
    end
    return h;
  endfunction

  // present one request and hold it until the block takes it
  task automatic issue_request(input in_t h, input logic csum_given, input logic [15:0] csum);
    start          <= 1'b1;
    in_hdr         <= h;
    row_csum_given <= csum_given;
    row_csum       <= csum;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every queued byte has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (hdr_bytes_due.size() != 0);
  endtask

  // result check, accept-side prediction and the watchdog, all on one edge
  always @(posedge clk) begin : scoreboard
    out_t        due;
    logic [15:0] csum;
    int          idle_cycles;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_strobe) begin
        if (hdr_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("byte %0d (%02h) with nothing outstanding",
                                  out_res.byte_index, out_res.header_byte));
        end else begin
          due = hdr_bytes_due.pop_front();
          if (out_res.header_byte !== due.header_byte)
            flag_mismatch($sformatf("byte %0d: header_byte %02h, predicted %02h",
                                    due.byte_index, out_res.header_byte, due.header_byte));
          if (out_res.byte_index !== due.byte_index)
            flag_mismatch($sformatf("byte_index %0d, predicted %0d",
                                    out_res.byte_index, due.byte_index));
          if (out_res.final_byte !== due.final_byte)
            flag_mismatch($sformatf("byte %0d: final_byte %b, predicted %b",
                                    due.byte_index, out_res.final_byte, due.final_byte));
          if (out_res.computed_checksum !== due.computed_checksum)
            flag_mismatch($sformatf("byte %0d: checksum %04h, predicted %04h", due.byte_index,
                                    out_res.computed_checksum, due.computed_checksum));
        end
      end
      // request transaction taken on this edge
      if (start && !busy) begin
        csum = row_csum_given ? row_csum : predict_csum(in_hdr);
        expect_header_bytes(in_hdr, csum);
      end
      if (out_strobe || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_hdr         <= '0;
    row_csum_given <= 1'b0;
    row_csum       <= '0;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, with a few gaps so a request lands mid-serialisation
    for (int n = 0; n < DIR_ROWS; n++) begin
      row = dir_row(n);
      if (n % 4 == 3) hold_off($urandom_range(1, 15));
      issue_request(row.hdr, row.csum_given, row.csum);
    end
    drain();

    // random part; items 120 to 199 run back to back
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 240) drain();
      if ((n < 120 || n >= 200) && $urandom_range(99) < 30)
        hold_off($urandom_range(1, 30));
      issue_request(random_header(), 1'b0, 16'h0000);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
